// ===== hw/rtl/swcr_pkg.sv =====
// Shared constants and controller/datapath interface types for the window rate block.
package swcr_pkg;

  // Field widths
  localparam int CNT_W   = 16;
  localparam int SUM_W   = 22;
  localparam int COEFF_W = 20;
  localparam int RATE_W  = 32;

  // Default window length in buckets
  localparam int WINDOW_BUCKETS_DEF = 60;

  // Dead-time coefficient after reset (about 1.8833e-6 in Q0.32)
  localparam logic [COEFF_W-1:0] COEFF_RESET = 20'd8089;

  // The quotient has RATE_W bits once overflow has been excluded.
  localparam int DIV_STEPS = RATE_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // take the input transfer, start the ring read
    logic update;  // update window sum, ring, slot and total
    logic mul;     // form sum * coeff
    logic check;   // form denominator and saturation flags
    logic step;    // one restoring division step
    logic finish;  // load the result register and the peak
  } swcr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic skip;    // rate is forced to maximum, division not needed
  } swcr_stat_t;

endpackage

// ===== hw/rtl/swcr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 60,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/swcr_ctrl.sv =====
// Controller state machine that sequences one bucket through the datapath.
module swcr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output swcr_pkg::swcr_cmd_t   cmd,
  input  swcr_pkg::swcr_stat_t  stat
);
  import swcr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  // The result register can be reloaded once it is empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  // Next-state and command decode.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.update = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (stat.skip || step_r == LAST_STEP) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/swcr_dp.sv =====
// Datapath: bucket ring, window sum, dead-time multiply, divider and result register.
module swcr_dp #(
  parameter int WINDOW_BUCKETS = swcr_pkg::WINDOW_BUCKETS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  swcr_pkg::swcr_cmd_t             cmd,
  output swcr_pkg::swcr_stat_t            stat,
  input  logic [swcr_pkg::CNT_W-1:0]      in_bucket_count,
  input  logic                            cfg_we,
  input  logic [swcr_pkg::COEFF_W-1:0]    cfg_wdata,
  output logic [swcr_pkg::RATE_W-1:0]     out_corrected_rate,
  output logic [swcr_pkg::SUM_W-1:0]      out_window_sum,
  output logic [swcr_pkg::RATE_W-1:0]     out_peak_rate,
  output logic [swcr_pkg::RATE_W-1:0]     out_total_pulses,
  output logic                            out_rate_saturated
);
  import swcr_pkg::*;

  localparam int SLOT_W = (WINDOW_BUCKETS > 1) ? $clog2(WINDOW_BUCKETS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_BUCKETS - 1);
  localparam int PROD_W = SUM_W + COEFF_W;
  localparam int DEN_W  = RATE_W + 1;
  localparam logic [DEN_W-1:0] DEN_ONE = {1'b1, {RATE_W{1'b0}}};

  logic [CNT_W-1:0]          count_r;
  logic [WINDOW_BUCKETS-1:0] valid_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [SUM_W-1:0]          sum_r;
  logic [RATE_W-1:0]         total_r;
  logic [RATE_W-1:0]         peak_r;
  logic [COEFF_W-1:0]        coeff_r;
  logic [PROD_W-1:0]         prod_r;
  logic [DEN_W-1:0]          den_r;
  logic [DEN_W-1:0]          rem_r;
  logic [RATE_W-1:0]         quot_r;
  logic                      sat_r;
  logic                      ovf_r;

  logic [CNT_W-1:0]  ram_rdata;
  logic [CNT_W-1:0]  old_count;
  logic [DEN_W-1:0]  den_nxt;
  logic [DEN_W:0]    trial;
  logic [RATE_W-1:0] rate;
  logic [RATE_W-1:0] peak_nxt;

  logic [RATE_W-1:0] out_rate_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic [RATE_W-1:0] out_peak_r;
  logic [RATE_W-1:0] out_total_r;
  logic              out_sat_r;

  // Ring of the last bucket counts; the old count at the write slot is read first.
  swcr_ram #(
    .WIDTH (CNT_W),
    .DEPTH (WINDOW_BUCKETS)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (slot_r),
    .wdata (count_r),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  // A slot never written since reset reads as zero.
  assign old_count = valid_r[slot_r] ? ram_rdata : '0;

  // Denominator 2^32 - sum*coeff, meaningful only when the product is below 2^32.
  assign den_nxt = DEN_ONE - {1'b0, prod_r[RATE_W-1:0]};

  // Restoring division step: trial subtract of the denominator.
  assign trial = {1'b0, rem_r[DEN_W-2:0], 1'b0} - {1'b0, den_r};

  // Saturated or overflowing quotients give the maximum rate.
  assign rate     = (sat_r || ovf_r) ? '1 : quot_r;
  assign peak_nxt = (rate > peak_r) ? rate : peak_r;

  assign stat.skip = sat_r || ovf_r;

  // Control-like state: ring valid bits, slot, sums, peak and coefficient.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      slot_r  <= '0;
      sum_r   <= '0;
      total_r <= '0;
      peak_r  <= '0;
      coeff_r <= COEFF_RESET;
    end else begin
      if (cfg_we) begin
        coeff_r <= cfg_wdata;
      end
      if (cmd.update) begin
        sum_r           <= sum_r - SUM_W'(old_count) + SUM_W'(count_r);
        total_r         <= total_r + RATE_W'(count_r);
        valid_r[slot_r] <= 1'b1;
        slot_r          <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
      end
      if (cmd.finish) begin
        peak_r <= peak_nxt;
      end
    end
  end

  // Arithmetic pipeline and result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      count_r <= in_bucket_count;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(sum_r) * PROD_W'(coeff_r);
    end
    if (cmd.check) begin
      sat_r  <= |prod_r[PROD_W-1:RATE_W];
      den_r  <= den_nxt;
      // Quotient exceeds 32 bits exactly when sum >= denominator.
      ovf_r  <= DEN_W'(sum_r) >= den_nxt;
      rem_r  <= DEN_W'(sum_r);
      quot_r <= '0;
    end
    if (cmd.step) begin
      if (!trial[DEN_W]) begin
        rem_r  <= trial[DEN_W-1:0];
        quot_r <= {quot_r[RATE_W-2:0], 1'b1};
      end else begin
        rem_r  <= {rem_r[DEN_W-2:0], 1'b0};
        quot_r <= {quot_r[RATE_W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      out_rate_r  <= rate;
      out_sum_r   <= sum_r;
      out_peak_r  <= peak_nxt;
      out_total_r <= total_r;
      out_sat_r   <= sat_r;
    end
  end

  assign out_corrected_rate = out_rate_r;
  assign out_window_sum     = out_sum_r;
  assign out_peak_rate      = out_peak_r;
  assign out_total_pulses   = out_total_r;
  assign out_rate_saturated = out_sat_r;

endmodule

// ===== hw/rtl/sliding_window_count_rate_top.sv =====
// Top level of the sliding-window count rate block with dead-time correction.
//
//   Channel  Ports                         Transfer when
//   input    in_valid/in_ready, in_*       in_valid && in_ready
//   result   out_valid/out_ready, out_*    out_valid && out_ready
//   config   cfg_we, cfg_wdata             cfg_we (no wait, no read-back)
//
// From its input transfer a bucket passes through the controller states in order: the
// ring read overlaps the transfer, then come the window update, the multiply, the
// denominator, the restoring division steps and the result load. A saturated or
// overflowing rate leaves the divider after one step. A new input transfer is taken
// only after the result load, and a stalled output holds the controller before the
// result load. Reset is synchronous and active low; the ring reads as zero after reset.
module sliding_window_count_rate_top #(
  parameter int WINDOW_BUCKETS = swcr_pkg::WINDOW_BUCKETS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [swcr_pkg::CNT_W-1:0]    in_bucket_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swcr_pkg::RATE_W-1:0]   out_corrected_rate,
  output logic [swcr_pkg::SUM_W-1:0]    out_window_sum,
  output logic [swcr_pkg::RATE_W-1:0]   out_peak_rate,
  output logic [swcr_pkg::RATE_W-1:0]   out_total_pulses,
  output logic                          out_rate_saturated,
  input  logic                          cfg_we,
  input  logic [swcr_pkg::COEFF_W-1:0]  cfg_wdata
);
  import swcr_pkg::*;

  swcr_cmd_t  cmd;
  swcr_stat_t stat;

  // Sequencer for one bucket at a time.
  swcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Ring, arithmetic and result register.
  swcr_dp #(
    .WINDOW_BUCKETS (WINDOW_BUCKETS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_bucket_count    (in_bucket_count),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_corrected_rate (out_corrected_rate),
    .out_window_sum     (out_window_sum),
    .out_peak_rate      (out_peak_rate),
    .out_total_pulses   (out_total_pulses),
    .out_rate_saturated (out_rate_saturated)
  );

endmodule

// ===== hw/rtl/swcr_chk.sv =====
// Port-level checker for the window rate block, bound to the top level.
module swcr_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [swcr_pkg::RATE_W-1:0]   out_corrected_rate,
  input logic [swcr_pkg::RATE_W-1:0]   out_peak_rate,
  input logic                          out_rate_saturated
);
  import swcr_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  // Only one bucket is in work: the input closes right after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a bucket is in work");

  // A saturated rate is reported as the maximum value.
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rate_saturated |-> out_corrected_rate == '1)
    else $error("saturated rate is not the maximum");

  // The peak never falls below the rate it accompanies.
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_rate >= out_corrected_rate)
    else $error("peak below current rate");

endmodule

bind sliding_window_count_rate_top swcr_chk u_swcr_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_corrected_rate (out_corrected_rate),
  .out_peak_rate      (out_peak_rate),
  .out_rate_saturated (out_rate_saturated)
);

// ===== test/sliding_window_count_rate_top_test.sv =====
// Self-checking testbench for the sliding-window count rate block.
`timescale 1ns / 100ps

module sliding_window_count_rate_top_test;
  import swcr_pkg::*;

  localparam int WINDOW        = WINDOW_BUCKETS_DEF;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 322;
  localparam logic [COEFF_W-1:0] COEFF_MAX = '1;

  // One result as the block should present it.
  typedef struct {
    logic [RATE_W-1:0] rate;
    logic [SUM_W-1:0]  sum;
    logic [RATE_W-1:0] peak;
    logic [RATE_W-1:0] total;
    logic              saturated;
  } rate_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CNT_W-1:0]     in_bucket_count = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [RATE_W-1:0]    out_corrected_rate;
  logic [SUM_W-1:0]     out_window_sum;
  logic [RATE_W-1:0]    out_peak_rate;
  logic [RATE_W-1:0]    out_total_pulses;
  logic                 out_rate_saturated;
  logic                 cfg_we = 1'b0;
  logic [COEFF_W-1:0]   cfg_wdata = '0;

  // Buckets waiting to be offered, and results still owed by the block.
  logic [CNT_W-1:0] pending_buckets[$];
  rate_result_t     expected_rates[$];

  // Our own copy of the block's state and coefficient.
  logic [CNT_W-1:0]   bucket_hist [WINDOW];
  int                 next_slot = 0;
  logic [SUM_W-1:0]   window_total = '0;
  logic [RATE_W-1:0]  peak_seen = '0;
  logic [RATE_W-1:0]  pulse_total = '0;
  logic [COEFF_W-1:0] coeff_now = COEFF_RESET;

  int   fail_count = 0;
  int   results_seen = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  bit   steady_flow = 1'b0;

  sliding_window_count_rate_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_bucket_count    (in_bucket_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_corrected_rate (out_corrected_rate),
    .out_window_sum     (out_window_sum),
    .out_peak_rate      (out_peak_rate),
    .out_total_pulses   (out_total_pulses),
    .out_rate_saturated (out_rate_saturated),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Advances the window by one bucket and works out the corrected rate.
  function automatic rate_result_t predict_window_rate(input logic [CNT_W-1:0] count);
    rate_result_t r;
    logic [63:0]  prod;
    logic [63:0]  quo;
    window_total = window_total - SUM_W'(bucket_hist[next_slot]) + SUM_W'(count);
    bucket_hist[next_slot] = count;
    next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
    pulse_total = pulse_total + RATE_W'(count);
    prod = 64'(window_total) * 64'(coeff_now);
    if (prod >= 64'h1_0000_0000) begin
      r.saturated = 1'b1;
      r.rate = '1;
    end else begin
      r.saturated = 1'b0;
      quo = {10'b0, window_total, 32'b0} / (64'h1_0000_0000 - prod);
      r.rate = (quo > 64'hFFFF_FFFF) ? '1 : quo[31:0];
    end
    if (r.rate > peak_seen) peak_seen = r.rate;
    r.sum = window_total;
    r.peak = peak_seen;
    r.total = pulse_total;
    return r;
  endfunction

  // Window sum that a bucket of the given count would produce next.
  function automatic logic [63:0] sum_after(input logic [CNT_W-1:0] count);
    return 64'(window_total) - 64'(bucket_hist[next_slot]) + 64'(count);
  endfunction

  // Mixes quiet, busy and extreme buckets; heavy sets the share of full-range counts.
  function automatic logic [CNT_W-1:0] random_count(input int heavy);
    int sel;
    sel = $urandom_range(99);
    if (sel < heavy) return CNT_W'($urandom_range(65535));
    if (sel < heavy + 6) return ($urandom_range(1) != 0) ? '1 : '0;
    if (sel < heavy + 30) return CNT_W'($urandom_range(4095));
    return CNT_W'($urandom_range(255));
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR: result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
    fail_count++;
  endtask

  // Waits until every bucket has been taken and every result has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_buckets.size() != 0 || in_valid || expected_rates.size() != 0)
      @(negedge clk);
  endtask

  // The block is idle here, so the new coefficient applies from the next bucket on.
  task automatic write_coeff(input logic [COEFF_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    coeff_now = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [COEFF_W-1:0] coeff, input int heavy,
                                  input int count);
    wait_drained();
    write_coeff(coeff);
    @(negedge clk);
    repeat (count) pending_buckets.push_back(random_count(heavy));
  endtask

  // Offers buckets from the queue, with random gaps unless the flow is steady.
  always @(posedge clk) begin : drive_buckets
    logic fire;
    fire = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) expected_rates.push_back(predict_window_rate(in_bucket_count));
      if (in_valid && !fire) begin
        // Hold the offer until the transfer happens.
      end else if (pending_buckets.size() != 0 &&
                   (steady_flow || $urandom_range(99) >= 23)) begin
        in_valid <= 1'b1;
        in_bucket_count <= pending_buckets.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Checks each result transfer and decides when to take the next one.
  always @(posedge clk) begin : check_results
    rate_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_rates.size() == 0) begin
          report_mismatch("unexpected result, corrected_rate", 64'(out_corrected_rate),
                          64'd0);
        end else begin
          want = expected_rates.pop_front();
          if (out_corrected_rate !== want.rate)
            report_mismatch("corrected_rate", 64'(out_corrected_rate), 64'(want.rate));
          if (out_window_sum !== want.sum)
            report_mismatch("window_sum", 64'(out_window_sum), 64'(want.sum));
          if (out_peak_rate !== want.peak)
            report_mismatch("peak_rate", 64'(out_peak_rate), 64'(want.peak));
          if (out_total_pulses !== want.total)
            report_mismatch("total_pulses", 64'(out_total_pulses), 64'(want.total));
          if (out_rate_saturated !== want.saturated)
            report_mismatch("rate_saturated", 64'(out_rate_saturated),
                            64'(want.saturated));
        end
      end
      // One long hold-off lets the block fill up and back-pressure its input.
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady_flow || ($urandom_range(99) >= 23);
      end
    end
  end

  // Guards against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] target;
    logic [63:0] coeff_calc;
    for (int i = 0; i < WINDOW; i++) bucket_hist[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes and alternating bits under the reset coefficient, then a run
    // of full buckets that drives the denominator to zero or below.
    @(negedge clk);
    pending_buckets.push_back(16'h0000);
    pending_buckets.push_back(16'hFFFF);
    pending_buckets.push_back(16'h0001);
    pending_buckets.push_back(16'h5555);
    pending_buckets.push_back(16'hAAAA);
    pending_buckets.push_back(16'h8000);
    repeat (9) pending_buckets.push_back(16'hFFFF);
    wait_drained();

    // Largest coefficient that keeps the denominator positive: the quotient
    // overflows and the rate clips without the saturation flag.
    target = sum_after(16'hFFFF);
    coeff_calc = 64'hFFFF_FFFF / target;
    write_coeff(COEFF_W'(coeff_calc));
    @(negedge clk);
    pending_buckets.push_back(16'hFFFF);
    wait_drained();

    // Smallest coefficient that makes the denominator not positive.
    target = sum_after(16'h0000);
    coeff_calc = (64'h1_0000_0000 + target - 1) / target;
    write_coeff(COEFF_W'(coeff_calc));
    @(negedge clk);
    pending_buckets.push_back(16'h0000);
    wait_drained();

    // Just under that boundary once more, at a different window sum.
    target = sum_after(16'h7FFF);
    coeff_calc = (64'h1_0000_0000 + target - 1) / target - 1;
    write_coeff(COEFF_W'(coeff_calc));
    @(negedge clk);
    pending_buckets.push_back(16'h7FFF);

    // Random phases across the coefficient range, extremes included.
    run_random_phase(COEFF_RESET, 20, PHASE_ITEMS);
    run_random_phase('0, 50, PHASE_ITEMS);
    run_random_phase(COEFF_MAX, 15, PHASE_ITEMS);
    run_random_phase(COEFF_W'($urandom_range(1048575)), 30, PHASE_ITEMS);
    run_random_phase(COEFF_W'($urandom_range(16383)), 60, PHASE_ITEMS);
    wait_drained();
    steady_flow = 1'b1;
    run_random_phase(COEFF_RESET, 70, PHASE_ITEMS);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/swcr_pkg.sv
hw/rtl/swcr_ram.sv
hw/rtl/swcr_ctrl.sv
hw/rtl/swcr_dp.sv
hw/rtl/sliding_window_count_rate_top.sv
hw/rtl/swcr_chk.sv
test/sliding_window_count_rate_top_test.sv
